// ===== rtl/core/sfd_pkg.sv =====
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared constants and controller/datapath interface types for the SBUS
// frame decoder.
// ----------------------------------------------------------------------------
package sfd_pkg;

    localparam int unsigned ByteW      = 8;
    localparam int unsigned ChanW      = 11;
    localparam int unsigned ChanIdxW   = 4;
    localparam int unsigned Channels   = 16;
    localparam int unsigned PosW       = 5;
    localparam int unsigned BufW       = 18;
    localparam int unsigned CntW       = 5;

    localparam logic [PosW-1:0]  POS_HEADER  = 5'd0;
    localparam logic [PosW-1:0]  POS_LAST_CH = 5'd22;
    localparam logic [PosW-1:0]  POS_FLAGS   = 5'd23;
    localparam logic [PosW-1:0]  POS_FOOTER  = 5'd24;
    localparam logic [PosW-1:0]  POS_IDLE    = 5'd31;

    localparam logic [ByteW-1:0] HEADER_BYTE = 8'h0F;
    localparam logic [ByteW-1:0] FOOTER_BYTE = 8'h00;
    localparam int unsigned      LostBit     = 2;

    localparam logic [ChanIdxW-1:0] LAST_CHAN = 4'd15;

    // Controller to datapath
    typedef struct packed {
        logic accept;     // take the byte on the input channel
        logic load_good;  // load next stored channel into the output stage
        logic load_bad;   // load the bad-frame result into the output stage
    } sfd_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic frame_end;  // current input byte is the footer of a frame
        logic frame_ok;   // header and footer both match
        logic emit_last;  // next channel to emit is the final one
        logic out_free;   // output stage can take a new item this cycle
    } sfd_status_t;

endpackage

// ===== rtl/core/sfd_ctrl.sv =====
// ----------------------------------------------------------------------------
// sfd_ctrl
// Controller: takes bytes, then drives the end-of-frame result burst.
// ----------------------------------------------------------------------------
module sfd_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sfd_pkg::sfd_status_t status,
    output sfd_pkg::sfd_cmd_t    cmd
);
    import sfd_pkg::*;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_EMIT,
        ST_BAD
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    assign in_ready = ready_reg;

    // Decode commands from state
    always_comb begin
        cmd            = '0;
        state_next     = state_reg;
        cmd.accept     = ready_reg && in_valid;
        case (state_reg)
            ST_RUN: begin
                if (cmd.accept && status.frame_end) begin
                    state_next = status.frame_ok ? ST_EMIT : ST_BAD;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.load_good = 1'b1;
                    if (status.emit_last) begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_BAD: begin
                if (status.out_free) begin
                    cmd.load_bad = 1'b1;
                    state_next   = ST_RUN;
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
        ready_next = (state_next == ST_RUN);
    end

    // Hold state and ready
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RUN;
            ready_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

endmodule

// ===== rtl/core/sfd_datapath.sv =====
// ----------------------------------------------------------------------------
// sfd_datapath
// Byte position tracking, bit unpacking into the channel store, frame check
// and the output register.
// ----------------------------------------------------------------------------
module sfd_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [sfd_pkg::ByteW-1:0]           rx_byte,
    input  logic                                frame_start,
    input  sfd_pkg::sfd_cmd_t                   cmd,
    output sfd_pkg::sfd_status_t                status,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [sfd_pkg::ChanIdxW-1:0]        out_index,
    output logic [sfd_pkg::ChanW-1:0]           out_value,
    output logic                                out_good,
    output logic                                out_lost,
    output logic                                out_last
);
    import sfd_pkg::*;

    logic [PosW-1:0]     pos_reg, pos_next;
    logic                hdr_ok_reg, hdr_ok_next;
    logic [BufW-1:0]     buf_reg, buf_next;
    logic [CntW-1:0]     nbits_reg, nbits_next;
    logic [CntW-1:0]     filled_reg, filled_next;
    logic                lost_reg, lost_next;
    logic [ChanIdxW-1:0] emit_idx_reg, emit_idx_next;
    logic                valid_reg, valid_next;

    logic [ChanIdxW-1:0] index_reg;
    logic [ChanW-1:0]    value_reg;
    logic                good_reg, lost_out_reg, last_reg;

    logic [ChanW-1:0]    store [Channels];

    logic [PosW-1:0]     eff_pos;
    logic [BufW-1:0]     eff_buf, merged;
    logic [CntW-1:0]     eff_nbits, nb_sum;
    logic [CntW-1:0]     eff_filled;
    logic                store_we;
    logic [ChanW-1:0]    store_wdata;

    // Apply a start mark ahead of the byte itself
    always_comb begin
        eff_pos    = frame_start ? POS_HEADER : pos_reg;
        eff_buf    = frame_start ? '0 : buf_reg;
        eff_nbits  = frame_start ? '0 : nbits_reg;
        eff_filled = frame_start ? '0 : filled_reg;
        merged     = eff_buf | ({{(BufW-ByteW){1'b0}}, rx_byte} << eff_nbits[3:0]);
        nb_sum     = eff_nbits + 5'd8;
    end

    // Advance frame state on an accepted byte
    always_comb begin
        pos_next    = pos_reg;
        hdr_ok_next = hdr_ok_reg;
        buf_next    = buf_reg;
        nbits_next  = nbits_reg;
        filled_next = filled_reg;
        lost_next   = lost_reg;
        store_we    = 1'b0;
        store_wdata = merged[ChanW-1:0];
        emit_idx_next = emit_idx_reg;

        if (cmd.accept) begin
            if (frame_start) begin
                hdr_ok_next = 1'b0;
                buf_next    = '0;
                nbits_next  = '0;
                filled_next = '0;
                lost_next   = 1'b0;
                pos_next    = POS_HEADER;
            end
            if (eff_pos == POS_HEADER) begin
                hdr_ok_next = (rx_byte == HEADER_BYTE);
                pos_next    = eff_pos + 5'd1;
            end else if (eff_pos <= POS_LAST_CH) begin
                if (nb_sum >= 5'd11) begin
                    store_we    = !eff_filled[CntW-1];
                    filled_next = eff_filled + 5'd1;
                    buf_next    = merged >> ChanW;
                    nbits_next  = nb_sum - 5'd11;
                end else begin
                    buf_next    = merged;
                    nbits_next  = nb_sum;
                end
                pos_next = eff_pos + 5'd1;
            end else if (eff_pos == POS_FLAGS) begin
                lost_next = rx_byte[LostBit];
                pos_next  = eff_pos + 5'd1;
            end else if (eff_pos == POS_FOOTER) begin
                pos_next      = POS_IDLE;
                emit_idx_next = '0;
            end
        end

        if (cmd.load_good) begin
            emit_idx_next = emit_idx_reg + 4'd1;
        end
    end

    // Report to the controller
    always_comb begin
        status.frame_end = (eff_pos == POS_FOOTER);
        status.frame_ok  = hdr_ok_reg && !frame_start && (rx_byte == FOOTER_BYTE);
        status.emit_last = (emit_idx_reg == LAST_CHAN);
        status.out_free  = !valid_reg || out_ready;
    end

    // Output valid: set on load, drop when taken
    always_comb begin
        if (cmd.load_good || cmd.load_bad) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= POS_IDLE;
            hdr_ok_reg   <= 1'b0;
            buf_reg      <= '0;
            nbits_reg    <= '0;
            filled_reg   <= '0;
            lost_reg     <= 1'b0;
            emit_idx_reg <= '0;
            valid_reg    <= 1'b0;
        end else begin
            pos_reg      <= pos_next;
            hdr_ok_reg   <= hdr_ok_next;
            buf_reg      <= buf_next;
            nbits_reg    <= nbits_next;
            filled_reg   <= filled_next;
            lost_reg     <= lost_next;
            emit_idx_reg <= emit_idx_next;
            valid_reg    <= valid_next;
        end
    end

    // Channel store write
    always_ff @(posedge aclk) begin
        if (store_we) begin
            store[eff_filled[ChanIdxW-1:0]] <= store_wdata;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (cmd.load_good) begin
            index_reg    <= emit_idx_reg;
            value_reg    <= store[emit_idx_reg];
            good_reg     <= 1'b1;
            lost_out_reg <= lost_reg;
            last_reg     <= (emit_idx_reg == LAST_CHAN);
        end else if (cmd.load_bad) begin
            index_reg    <= '0;
            value_reg    <= '0;
            good_reg     <= 1'b0;
            lost_out_reg <= 1'b0;
            last_reg     <= 1'b1;
        end
    end

    assign out_valid = valid_reg;
    assign out_index = index_reg;
    assign out_value = value_reg;
    assign out_good  = good_reg;
    assign out_lost  = lost_out_reg;
    assign out_last  = last_reg;

endmodule

// ===== rtl/core/sbus_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// sbus_frame_decoder
// SBUS 25-byte frame decoder producing sixteen 11-bit channel items.
// ----------------------------------------------------------------------------
// Input channel s_*: one received byte per item, s_tuser marks the first byte
// after an idle line. Bytes 1..22 are unpacked LSB first into a 16-entry
// channel store; byte 23 bit 2 is the frame-lost flag; byte 24 is the footer.
// Output channel m_*: on a good frame (header 0x0F, footer 0x00) sixteen items
// carry channels 0..15 with m_tlast on channel 15; on a bad frame one item
// with m_tuser low, zero data and m_tlast set.
// Timing: after the footer byte the input stalls while the output register
// drains the store one channel per cycle, unless the receiver stalls. The
// first result is loaded into the output register after the controller
// has registered its move out of the run state on the footer byte.
// Reset: synchronous, active low; no frame in progress, output empty, s_tready
// is registered and rises in the cycle after release. A stalled receiver
// holds the current item and pauses the burst; a byte may still be taken
// while the last item of the previous frame waits.
// ----------------------------------------------------------------------------
module sbus_frame_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [3:0] channel_index, [14:4] channel_value,
                                   // [15] frame_lost
    output logic        m_tuser,   // [0] frame_good
    output logic        m_tlast    // last
);
    import sfd_pkg::*;

    sfd_cmd_t            cmd;
    sfd_status_t         status;
    logic [ChanIdxW-1:0] out_index;
    logic [ChanW-1:0]    out_value;
    logic                out_lost;

    sfd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sfd_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .rx_byte     (s_tdata),
        .frame_start (s_tuser),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_index   (out_index),
        .out_value   (out_value),
        .out_good    (m_tuser),
        .out_lost    (out_lost),
        .out_last    (m_tlast)
    );

    // Pack result fields
    assign m_tdata = {out_lost, out_value, out_index};

endmodule

// ===== rtl/core/sfd_checker.sv =====
// ----------------------------------------------------------------------------
// sfd_checker
// Port-level checks on the SBUS frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
module sfd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // Hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // Bad frame gives one zero item with last set
    a_bad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tlast && (m_tdata == 16'd0))
        else $error("bad-frame item malformed");

    // Last good item is channel 15 and only channel 15
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (m_tlast == (m_tdata[3:0] == 4'd15)))
        else $error("last flag does not match channel 15");

    // Burst advances to the next channel right after a take
    a_next: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tuser && !m_tlast |=>
        m_tvalid && m_tuser && (m_tdata[3:0] == $past(m_tdata[3:0]) + 4'd1))
        else $error("channel burst skipped or stalled");

    // Input is held off during a burst
    a_stall_in: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser && !m_tlast |-> !s_tready)
        else $error("input accepted during burst");

endmodule

bind sbus_frame_decoder sfd_checker u_sfd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 16-channel SBUS frame decoder. Bytes are sent
// as whole, broken, cut and noise frames; a scoreboard class mirrors the
// decoder state, predicts every channel item and checks each output item
// field by field in order. Both sides stall at random.
// ----------------------------------------------------------------------------
module testbench;

    import sfd_pkg::*;

    localparam int unsigned CycleLimit = 200000;
    localparam int unsigned FrameLen   = 25;
    localparam int unsigned RandomBytes = 350;

    typedef enum {FR_GOOD, FR_BAD_HEADER, FR_BAD_FOOTER, FR_CUT} frame_kind_t;
    typedef enum {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_t;

    typedef struct packed {
        logic [ChanIdxW-1:0] ch_index;
        logic [ChanW-1:0]    ch_value;
        logic                good;
        logic                lost;
        logic                fin;
    } chan_result_t;

    // Mirror of the decoder plus the queue of channel items still to come
    class frame_scoreboard;
        chan_result_t     expected_q[$];
        int               errors = 0;
        int               seen = 0;
        logic [PosW-1:0]  pos = POS_IDLE;
        logic             header_ok = 1'b0;
        logic [BufW-1:0]  bit_pool = '0;
        logic [CntW-1:0]  pool_count = '0;
        logic [ChanW-1:0] chan_store [Channels];
        logic [CntW-1:0]  filled = '0;
        logic             lost_flag = 1'b0;

        task report(string what);
            errors++;
            if (errors <= 100)
                $display("MISMATCH: %s", what);
        endtask

        function int pending();
            return expected_q.size();
        endfunction

        // Advance the mirror by one accepted byte
        function void note_byte(logic [ByteW-1:0] rx, logic start);
            chan_result_t r;
            if (start) begin
                pos        = POS_HEADER;
                header_ok  = 1'b0;
                bit_pool   = '0;
                pool_count = '0;
                filled     = '0;
                lost_flag  = 1'b0;
            end
            if (pos > POS_FOOTER)
                return;
            if (pos == POS_HEADER) begin
                header_ok = (rx == HEADER_BYTE);
            end else if (pos <= POS_LAST_CH) begin
                bit_pool   = bit_pool | (BufW'(rx) << pool_count[3:0]);
                pool_count = pool_count + 5'd8;
                if (pool_count >= 5'd11) begin
                    if (filled < Channels)
                        chan_store[filled[3:0]] = bit_pool[ChanW-1:0];
                    filled     = filled + 5'd1;
                    bit_pool   = bit_pool >> ChanW;
                    pool_count = pool_count - 5'd11;
                end
            end else if (pos == POS_FLAGS) begin
                lost_flag = rx[LostBit];
            end else begin
                // Footer: judge the frame and queue its items
                if (header_ok && rx == FOOTER_BYTE) begin
                    for (int i = 0; i < Channels; i++) begin
                        r.ch_index = ChanIdxW'(i);
                        r.ch_value = chan_store[i];
                        r.good     = 1'b1;
                        r.lost     = lost_flag;
                        r.fin      = (r.ch_index == LAST_CHAN);
                        expected_q.push_back(r);
                    end
                end else begin
                    r = '0;
                    r.fin = 1'b1;
                    expected_q.push_back(r);
                end
                pos = POS_IDLE;
                return;
            end
            pos = pos + 5'd1;
        endfunction

        // Compare one output item with the oldest expectation
        task check_result(logic [15:0] data, logic good, logic fin);
            chan_result_t e;
            seen++;
            if (expected_q.size() == 0) begin
                report($sformatf("item %0d arrived with nothing expected", seen));
                return;
            end
            e = expected_q.pop_front();
            if (data[3:0] !== e.ch_index)
                report($sformatf("item %0d channel_index %0d, want %0d",
                                 seen, data[3:0], e.ch_index));
            if (data[14:4] !== e.ch_value)
                report($sformatf("item %0d channel_value %0d, want %0d",
                                 seen, data[14:4], e.ch_value));
            if (good !== e.good)
                report($sformatf("item %0d frame_good %b, want %b", seen, good, e.good));
            if (data[15] !== e.lost)
                report($sformatf("item %0d frame_lost %b, want %b",
                                 seen, data[15], e.lost));
            if (fin !== e.fin)
                report($sformatf("item %0d last %b, want %b", seen, fin, e.fin));
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    frame_scoreboard sb = new();
    bit              steady = 1'b0;
    int unsigned     cycle_count = 0;
    int              bytes_sent = 0;

    sbus_frame_decoder dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Stall the receiver at random, except in the steady stretch
    always @(negedge aclk) begin
        m_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 26);
    end

    // Check every accepted output item
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser, m_tlast);
    end

    // Give up on a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Offer one byte, with random idle cycles ahead of it; call at a falling edge
    task send_byte(input logic [7:0] rx, input logic start);
        while (!steady && $urandom_range(0, 99) < 26) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rx;
        s_tuser  <= start;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.note_byte(rx, start);
        @(negedge aclk);
    endtask

    // Hold the sender until every expected item has come out
    task drain_outputs();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (sb.pending() != 0)
            @(negedge aclk);
    endtask

    // Bytes with no start mark; ignored while no frame is open
    task send_noise(input int count);
        for (int i = 0; i < count; i++)
            send_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // Build one frame of the given kind and send it (a cut frame stops early)
    task send_frame(input frame_kind_t kind, input fill_t fill);
        logic [7:0] fr [FrameLen];
        int         len;
        fr[0] = HEADER_BYTE;
        for (int i = 1; i < FrameLen - 1; i++) begin
            case (fill)
                FILL_ONES:  fr[i] = 8'hFF;
                FILL_ZEROS: fr[i] = 8'h00;
                default:    fr[i] = 8'($urandom_range(0, 255));
            endcase
        end
        fr[FrameLen-1] = FOOTER_BYTE;
        len = FrameLen;
        case (kind)
            FR_BAD_HEADER: begin
                do fr[0] = 8'($urandom_range(0, 255));
                while (fr[0] == HEADER_BYTE);
            end
            FR_BAD_FOOTER: fr[FrameLen-1] = 8'($urandom_range(1, 255));
            FR_CUT:        len = $urandom_range(1, FrameLen - 1);
            default: ;
        endcase
        for (int i = 0; i < len; i++)
            send_byte(fr[i], i == 0);
        bytes_sent += len;
    endtask

    initial begin
        int          frame_no;
        int          pick;
        frame_kind_t kind;
        fill_t       fill;

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: idle-line bytes, a cut frame, a full-scale good frame,
        // bytes past the 25th, then a bad footer on an all-zero frame
        send_byte(HEADER_BYTE, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(HEADER_BYTE, 1'b1);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        send_frame(FR_GOOD, FILL_ONES);
        send_byte(8'hFF, 1'b0);
        send_byte(HEADER_BYTE, 1'b0);
        send_frame(FR_BAD_FOOTER, FILL_ZEROS);
        drain_outputs();

        // Random: mostly well-formed frames, some broken, cut or noisy
        frame_no = 0;
        while (bytes_sent < RandomBytes) begin
            steady = (frame_no >= 5 && frame_no < 9);
            pick = $urandom_range(0, 99);
            if (pick < 64)
                kind = FR_GOOD;
            else if (pick < 76)
                kind = FR_BAD_HEADER;
            else if (pick < 88)
                kind = FR_BAD_FOOTER;
            else
                kind = FR_CUT;
            pick = $urandom_range(0, 9);
            fill = (pick == 0) ? FILL_ONES : (pick == 1) ? FILL_ZEROS : FILL_RANDOM;
            send_frame(kind, fill);
            if (kind != FR_CUT)
                send_noise($urandom_range(0, 2));
            if (frame_no == 10)
                drain_outputs();
            frame_no++;
        end
        steady = 1'b0;

        drain_outputs();
        repeat (20) @(negedge aclk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d items never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
